### sv/itta_pkg.sv
// Shared types and constants of the speaker turn table.
package itta_pkg;

    localparam int ADDR_W = 11;
    localparam int TIME_W = 40;
    localparam int TOL_W = 24;
    localparam int DUR_W = 24;
    localparam int CONF_W = 16;
    localparam int SPK_W = 8;
    localparam int SLOT_W = 6;
    localparam int IN_DATA_W = 168;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_UNLIM = 2'd2;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        WSEL_SHIFT  = 2'd0,
        WSEL_MERGE  = 2'd1,
        WSEL_INSERT = 2'd2
    } wsel_t;

    typedef enum logic [1:0] {
        RES_MERGE = 2'd0,
        RES_FULL  = 2'd1,
        RES_INS   = 2'd2,
        RES_QUERY = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic              scan;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        wsel_t             wsel;
        logic [ADDR_W-1:0] wr_addr;
        logic              res_load;
        res_kind_t         res_kind;
    } cmd_t;

    typedef struct packed {
        logic              op;
        logic              merge_found;
        logic [ADDR_W-1:0] merge_idx;
        logic              pos_found;
        logic [ADDR_W-1:0] pos_idx;
    } sts_t;

endpackage

### sv/itta_ctrl.sv
// Sequencer for scans, table shifting and result hand-off.
module itta_ctrl
    import itta_pkg::*;
#(
    parameter int MAX_TURNS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int CW = $clog2(MAX_TURNS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DRAIN  = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_MERGE  = 9'b000010000,
        S_SH_RD  = 9'b000100000,
        S_SH_WR  = 9'b001000000,
        S_INSERT = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [1:0] drain_reg, drain_next;
    res_kind_t kind_reg, kind_next;
    logic out_valid_reg, out_valid_next;
    logic [CW-1:0] pos_pick;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_pick = sts.pos_found ? CW'(sts.pos_idx) : count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        drain_next = drain_reg;
        kind_next = kind_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        cmd.wsel = WSEL_SHIFT;
        cmd.res_kind = kind_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    drain_next = '0;
                    state_next = (count_reg == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                cmd.scan = 1'b1;
                cmd.rd_addr = ADDR_W'(idx_reg);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.op == OP_QUERY)
                begin
                    kind_next = RES_QUERY;
                    state_next = S_RESULT;
                end
                else if (sts.merge_found)
                begin
                    state_next = S_MERGE;
                end
                else if (count_reg == CW'(MAX_TURNS))
                begin
                    kind_next = RES_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    pos_next = pos_pick;
                    idx_next = count_reg;
                    state_next = (count_reg > pos_pick) ? S_SH_RD : S_INSERT;
                end
            end
            S_MERGE:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel = WSEL_MERGE;
                cmd.wr_addr = sts.merge_idx;
                kind_next = RES_MERGE;
                state_next = S_RESULT;
            end
            S_SH_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = ADDR_W'(idx_reg - 1'b1);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel = WSEL_SHIFT;
                cmd.wr_addr = ADDR_W'(idx_reg);
                idx_next = idx_reg - 1'b1;
                state_next = (idx_reg - 1'b1 > pos_reg) ? S_SH_RD : S_INSERT;
            end
            S_INSERT:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel = WSEL_INSERT;
                cmd.wr_addr = ADDR_W'(pos_reg);
                count_next = count_reg + 1'b1;
                kind_next = RES_INS;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            drain_reg <= '0;
            kind_reg <= RES_QUERY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            drain_reg <= drain_next;
            kind_reg <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/itta_dp.sv
// Turn memory, scan pipeline, configuration registers and result register.
module itta_dp
    import itta_pkg::*;
#(
    parameter int MAX_TURNS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    input  logic                  in_op,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int IW = (MAX_TURNS > 1) ? $clog2(MAX_TURNS) : 1;
    localparam int EW = 2 * TIME_W + CONF_W + SPK_W;

    typedef struct packed {
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic [CONF_W-1:0] conf;
        logic [SPK_W-1:0]  spk;
    } entry_t;

    logic [TOL_W-1:0] tol_reg;
    logic [TIME_W-1:0] snap_lim_reg;
    logic snap_unl_reg;

    logic op_reg;
    logic [TIME_W-1:0] ts_reg, te_reg, qt_reg;
    logic [CONF_W-1:0] tc_reg;
    logic [SPK_W-1:0] tk_reg;
    logic [TIME_W:0] qe_reg;

    logic [EW-1:0] mem [MAX_TURNS];
    entry_t rdata_reg;
    logic rvalid_reg;
    logic [IW-1:0] ridx_reg;
    entry_t wdata;

    // Stage one of the scan.
    logic s1_valid_reg, s1_hit_reg, s1_gt_reg, s1_ovp_reg, s1_dok_reg;
    logic [TIME_W:0] s1_ov_reg, s1_d_reg;
    logic [IW-1:0] s1_idx_reg;
    entry_t s1_ent_reg;
    logic [TIME_W:0] lo, hi, d1, d2, d;
    logic [TIME_W-1:0] sdiff;

    // Stage two: running bests.
    logic mf_reg, pf_reg, ovh_reg, snh_reg;
    logic [IW-1:0] mi_reg, pi_reg, ovi_reg, sni_reg;
    entry_t mh_reg, ovb_reg, snb_reg;
    logic [TIME_W:0] best_ov_reg, best_d_reg;

    // Slot of the last insertion, taken from the write address of the insert.
    logic [IW-1:0] ins_slot_reg;
    logic [OUT_DATA_W-1:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(160);
            snap_lim_reg <= '0;
            snap_unl_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_TOL: tol_reg <= cfg_data[TOL_W-1:0];
                CFG_SNAP_LIMIT: snap_lim_reg <= cfg_data;
                CFG_SNAP_UNLIM: snap_unl_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            ts_reg <= in_data[39:0];
            te_reg <= in_data[79:40];
            tc_reg <= in_data[95:80];
            tk_reg <= in_data[103:96];
            qt_reg <= in_data[143:104];
            qe_reg <= {1'b0, in_data[143:104]} + {17'd0, in_data[167:144]};
        end
    end

    always_comb
    begin
        wdata = rdata_reg;
        case (cmd.wsel)
            WSEL_MERGE:
            begin
                wdata.t_start = mh_reg.t_start;
                wdata.t_end = (te_reg > mh_reg.t_end) ? te_reg : mh_reg.t_end;
                wdata.conf = tc_reg;
                wdata.spk = (tk_reg != '0) ? tk_reg : mh_reg.spk;
            end
            WSEL_INSERT:
            begin
                wdata.t_start = ts_reg;
                wdata.t_end = te_reg;
                wdata.conf = tc_reg;
                wdata.spk = tk_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[IW-1:0]] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.rd_addr[IW-1:0]];
        end
        ridx_reg <= cmd.rd_addr[IW-1:0];
    end

    always_comb
    begin
        lo = (rdata_reg.t_start > qt_reg) ? {1'b0, rdata_reg.t_start} : {1'b0, qt_reg};
        hi = ({1'b0, rdata_reg.t_end} < qe_reg) ? {1'b0, rdata_reg.t_end} : qe_reg;
        d1 = (qt_reg > rdata_reg.t_end) ? {1'b0, qt_reg - rdata_reg.t_end}
                                        : {1'b0, rdata_reg.t_end - qt_reg};
        d2 = ({1'b0, rdata_reg.t_start} > qe_reg) ? {1'b0, rdata_reg.t_start} - qe_reg
                                                  : qe_reg - {1'b0, rdata_reg.t_start};
        d = (d1 < d2) ? d1 : d2;
        sdiff = (rdata_reg.t_start > ts_reg) ? rdata_reg.t_start - ts_reg
                                             : ts_reg - rdata_reg.t_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.scan;
            s1_valid_reg <= rvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg <= (sdiff <= {16'd0, tol_reg});
        s1_gt_reg <= (rdata_reg.t_start > ts_reg);
        s1_ovp_reg <= (hi > lo);
        s1_ov_reg <= hi - lo;
        s1_d_reg <= d;
        s1_dok_reg <= snap_unl_reg || (d <= {1'b0, snap_lim_reg});
        s1_idx_reg <= ridx_reg;
        s1_ent_reg <= rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mf_reg <= 1'b0;
            pf_reg <= 1'b0;
            ovh_reg <= 1'b0;
            snh_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            mf_reg <= 1'b0;
            pf_reg <= 1'b0;
            ovh_reg <= 1'b0;
            snh_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_hit_reg && !mf_reg)
            begin
                mf_reg <= 1'b1;
            end
            if (s1_gt_reg && !pf_reg)
            begin
                pf_reg <= 1'b1;
            end
            if (s1_ovp_reg && (!ovh_reg || s1_ov_reg > best_ov_reg))
            begin
                ovh_reg <= 1'b1;
            end
            if (s1_dok_reg && (!snh_reg || s1_d_reg < best_d_reg))
            begin
                snh_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !cmd.load)
        begin
            if (s1_hit_reg && !mf_reg)
            begin
                mi_reg <= s1_idx_reg;
                mh_reg <= s1_ent_reg;
            end
            if (s1_gt_reg && !pf_reg)
            begin
                pi_reg <= s1_idx_reg;
            end
            if (s1_ovp_reg && (!ovh_reg || s1_ov_reg > best_ov_reg))
            begin
                best_ov_reg <= s1_ov_reg;
                ovi_reg <= s1_idx_reg;
                ovb_reg <= s1_ent_reg;
            end
            if (s1_dok_reg && (!snh_reg || s1_d_reg < best_d_reg))
            begin
                best_d_reg <= s1_d_reg;
                sni_reg <= s1_idx_reg;
                snb_reg <= s1_ent_reg;
            end
        end
    end

    assign sts.op = op_reg;
    assign sts.merge_found = mf_reg;
    assign sts.merge_idx = ADDR_W'(mi_reg);
    assign sts.pos_found = pf_reg;
    assign sts.pos_idx = ADDR_W'(pi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wsel == WSEL_INSERT)
        begin
            ins_slot_reg <= cmd.wr_addr[IW-1:0];
        end
    end

    // Result word: found, snapped, speaker, conf, slot, merged, full from bit 0 up.
    always_comb
    begin
        res_next = '0;
        case (cmd.res_kind)
            RES_MERGE:
            begin
                res_next[31:26] = SLOT_W'(mi_reg);
                res_next[32] = 1'b1;
            end
            RES_FULL:
            begin
                res_next[33] = 1'b1;
            end
            RES_INS:
            begin
                res_next[31:26] = SLOT_W'(ins_slot_reg);
            end
            default:
            begin
                if (ovh_reg)
                begin
                    res_next[0] = 1'b1;
                    res_next[9:2] = ovb_reg.spk;
                    res_next[25:10] = ovb_reg.conf;
                    res_next[31:26] = SLOT_W'(ovi_reg);
                end
                else if (snh_reg)
                begin
                    res_next[0] = 1'b1;
                    res_next[1] = 1'b1;
                    res_next[9:2] = snb_reg.spk;
                    res_next[25:10] = snb_reg.conf;
                    res_next[31:26] = SLOT_W'(sni_reg);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data <= res_next;
        end
    end

endmodule

### sv/interval_turn_table_attributor_top.sv
// Top level of the speaker turn table with interval attribution.
//
// Requests enter on the s_axis group: s_axis_tuser carries the operation (0 offers a
// turn, 1 queries an interval) and s_axis_tdata carries the turn and query fields.
// Each request yields exactly one result on the m_axis group.
// The configuration port writes match_tolerance (index 0), snap_limit (index 1) and
// snap_unlimited (index 2); it should be used only while the block is idle.
// A request first scans the N stored turns through a registered memory read and a
// two-stage compare pipeline. A query or a dropped offer then has its result loaded,
// a merge after writing the merged entry; the next request can be accepted in the
// cycle after the result is loaded.
// An insertion moves each later entry up one place, reading it and then writing it one
// address higher, before the new turn is written; the longest case is an insertion at
// the front with 63 stored entries.
// The memory is accessed one entry per cycle, which sets the pace of scan and shift.
// Reset empties the table and restores the register defaults; entry contents are not
// cleared, since only entries below the fill count are read.
// The result register holds a finished result while m_axis_tready is low; the next
// request is accepted meanwhile and its result waits until the register is free.
module interval_turn_table_attributor_top
    import itta_pkg::*;
#(
    parameter int MAX_TURNS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // turn_start, turn_end, turn_conf, turn_speaker, query_time, query_dur
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found, snapped, speaker_out, conf_out, slot, merged, table_full, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cmd_t cmd;
    sts_t sts;

    itta_ctrl #(.MAX_TURNS(MAX_TURNS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    itta_dp #(.MAX_TURNS(MAX_TURNS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_axis_tdata)
    );

endmodule
